@@ hdl/dsfr_pkg.sv @@
package dsfr_pkg;

    localparam logic [7:0] DLE_BYTE  = 8'h10;
    localparam logic [7:0] STX_BYTE  = 8'h02;
    localparam logic [7:0] ETX_BYTE  = 8'h03;
    localparam logic [7:0] SUM_SEED  = 8'h12;
    localparam logic [7:0] NULL_BYTE = 8'h00;

    // Command queue depth between front and back (power of two, at least 2).
    localparam int QUEUE_DEPTH = 4;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHECKSUM_EXTRA_OFFSET = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_STRIP_NULL_PREAMBLE   = 1'd1;
    localparam int CFG_DATA_W = 8;

    localparam logic [7:0] OFFSET_RESET = 8'd5;
    localparam logic       STRIP_RESET  = 1'b1;

    typedef enum logic [2:0] {
        K_PAYLOAD   = 3'd0,
        K_GOOD      = 3'd1,
        K_CSUM_ERR  = 3'd2,
        K_TOO_SHORT = 3'd3,
        K_ABORT     = 3'd4
    } t_kind;

    // Commands the front hands to the back.
    typedef enum logic [1:0] {
        CMD_PUSH  = 2'd0,   // one data byte
        CMD_PUSH2 = 2'd1,   // DLE followed by a data byte
        CMD_END   = 2'd2,   // DLE ETX: judge the frame
        CMD_ABORT = 2'd3    // DLE STX inside a frame
    } t_cmd;

    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] data;
    } t_qentry;

    typedef struct packed {
        logic [7:0] checksum_extra_offset;
        logic       strip_null_preamble;
    } t_cfg;

endpackage

@@ hdl/dsfr_front.sv @@
module dsfr_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [7:0]        i_byte,
    input  logic              i_full,
    output logic              o_push,
    output dsfr_pkg::t_qentry o_entry
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_DLE_START,
        PH_DATA,
        PH_ESCAPE
    } t_phase;

    t_phase r_phase;
    t_phase n_phase;
    logic   accept;
    logic   has_cmd;

    assign accept = i_valid && !i_full;

    always_comb begin
        n_phase       = r_phase;
        has_cmd       = 1'b0;
        o_entry.cmd   = dsfr_pkg::CMD_PUSH;
        o_entry.data  = i_byte;
        case (r_phase)
            PH_IDLE: begin
                if (i_byte == dsfr_pkg::DLE_BYTE) begin
                    n_phase = PH_DLE_START;
                end
            end
            PH_DLE_START: begin
                n_phase = (i_byte == dsfr_pkg::STX_BYTE) ? PH_DATA : PH_IDLE;
            end
            PH_DATA: begin
                if (i_byte == dsfr_pkg::DLE_BYTE) begin
                    n_phase = PH_ESCAPE;
                end else begin
                    has_cmd = 1'b1;
                end
            end
            PH_ESCAPE: begin
                has_cmd = 1'b1;
                n_phase = PH_DATA;
                if (i_byte == dsfr_pkg::ETX_BYTE) begin
                    o_entry.cmd = dsfr_pkg::CMD_END;
                    n_phase     = PH_IDLE;
                end else if (i_byte == dsfr_pkg::DLE_BYTE) begin
                    o_entry.cmd = dsfr_pkg::CMD_PUSH;
                end else if (i_byte == dsfr_pkg::STX_BYTE) begin
                    o_entry.cmd = dsfr_pkg::CMD_ABORT;
                end else begin
                    o_entry.cmd = dsfr_pkg::CMD_PUSH2;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    assign o_push = accept && has_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
        end else if (accept) begin
            r_phase <= n_phase;
        end
    end

endmodule

@@ hdl/dsfr_queue.sv @@
module dsfr_queue #(
    parameter int DEPTH = dsfr_pkg::QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  dsfr_pkg::t_qentry i_entry,
    input  logic              i_pop,
    output logic              o_valid,
    output dsfr_pkg::t_qentry o_head,
    output logic              o_full
);

    localparam int AW = $clog2(DEPTH);

    dsfr_pkg::t_qentry r_mem [DEPTH];
    logic [AW-1:0]     r_wr;
    logic [AW-1:0]     r_rd;
    logic [AW:0]       r_count;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == (AW+1)'(DEPTH));
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`ifndef SYNTH
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full command queue");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty command queue");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (AW+1)'(DEPTH))
        else $error("command queue count overflow");
`endif

endmodule

@@ hdl/dsfr_back.sv @@
module dsfr_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dsfr_pkg::t_cfg    i_cfg,
    input  logic              i_head_valid,
    input  dsfr_pkg::t_qentry i_head,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [2:0]        o_kind,
    output logic [7:0]        o_value,
    output logic [7:0]        o_frame_address,
    output logic [7:0]        o_frame_function,
    output logic              o_last
);

    logic [7:0] r_held;
    logic       r_held_valid;
    logic [7:0] r_sum;
    logic [1:0] r_total;
    logic [1:0] r_kept;
    logic [7:0] r_addr;
    logic [7:0] r_func;
    logic       r_second;

    logic [7:0] n_held;
    logic       n_held_valid;
    logic [7:0] n_sum;
    logic [1:0] n_total;
    logic [1:0] n_kept;
    logic [7:0] n_addr;
    logic [7:0] n_func;

    logic              r_out_valid;
    dsfr_pkg::t_kind   r_kind;
    logic [7:0]        r_value;
    logic [7:0]        r_out_addr;
    logic [7:0]        r_out_func;
    logic              r_last;

    logic            ready;
    logic            do_step;
    logic            first_half;
    logic [7:0]      step_byte;
    logic            strip;
    logic            emit;
    dsfr_pkg::t_kind e_kind;
    logic [7:0]      e_value;
    logic [7:0]      e_addr;
    logic [7:0]      e_func;
    logic [7:0]      actual;
    logic [7:0]      alt;

    assign ready      = !r_out_valid || !i_stall;
    assign do_step    = i_head_valid && ready;
    assign first_half = (i_head.cmd == dsfr_pkg::CMD_PUSH2) && !r_second;
    assign step_byte  = first_half ? dsfr_pkg::DLE_BYTE : i_head.data;
    assign o_pop      = do_step && !first_half;
    assign actual     = r_held_valid ? r_held : 8'h00;
    assign alt        = r_sum + i_cfg.checksum_extra_offset;
    assign strip      = i_cfg.strip_null_preamble && (r_kept == 2'd0)
                        && (step_byte == dsfr_pkg::NULL_BYTE);

    always_comb begin
        n_held       = r_held;
        n_held_valid = r_held_valid;
        n_sum        = r_sum;
        n_total      = r_total;
        n_kept       = r_kept;
        n_addr       = r_addr;
        n_func       = r_func;
        emit         = 1'b0;
        e_kind       = dsfr_pkg::K_PAYLOAD;
        e_value      = r_held;
        e_addr       = r_addr;
        e_func       = r_func;
        case (i_head.cmd)
            dsfr_pkg::CMD_PUSH, dsfr_pkg::CMD_PUSH2: begin
                if (r_total != 2'd3) begin
                    n_total = r_total + 2'd1;
                end
                if (!strip) begin
                    if (r_kept == 2'd0) begin
                        n_addr = step_byte;
                    end else if (r_kept == 2'd1) begin
                        n_func = step_byte;
                    end
                    if (r_kept != 2'd3) begin
                        n_kept = r_kept + 2'd1;
                    end
                    if (r_held_valid) begin
                        n_sum = r_sum + r_held;
                        emit  = 1'b1;
                    end
                    n_held       = step_byte;
                    n_held_valid = 1'b1;
                end
                e_addr = n_addr;
                e_func = n_func;
            end
            dsfr_pkg::CMD_END: begin
                emit    = (r_total != 2'd0);
                e_value = actual;
                if (r_total != 2'd3) begin
                    e_kind = dsfr_pkg::K_TOO_SHORT;
                end else if (r_sum != actual && alt != actual) begin
                    e_kind = dsfr_pkg::K_CSUM_ERR;
                end else if (r_kept != 2'd3) begin
                    e_kind = dsfr_pkg::K_TOO_SHORT;
                end else begin
                    e_kind = dsfr_pkg::K_GOOD;
                end
            end
            default: begin
                emit    = 1'b1;
                e_kind  = dsfr_pkg::K_ABORT;
                e_value = 8'h00;
            end
        endcase
        // End and abort both leave a fresh empty frame behind.
        if (i_head.cmd == dsfr_pkg::CMD_END || i_head.cmd == dsfr_pkg::CMD_ABORT) begin
            n_held       = 8'h00;
            n_held_valid = 1'b0;
            n_sum        = dsfr_pkg::SUM_SEED;
            n_total      = 2'd0;
            n_kept       = 2'd0;
            n_addr       = 8'h00;
            n_func       = 8'h00;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held       <= 8'h00;
            r_held_valid <= 1'b0;
            r_sum        <= dsfr_pkg::SUM_SEED;
            r_total      <= 2'd0;
            r_kept       <= 2'd0;
            r_addr       <= 8'h00;
            r_func       <= 8'h00;
            r_second     <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (do_step) begin
                r_held       <= n_held;
                r_held_valid <= n_held_valid;
                r_sum        <= n_sum;
                r_total      <= n_total;
                r_kept       <= n_kept;
                r_addr       <= n_addr;
                r_func       <= n_func;
                r_second     <= first_half;
            end
            if (ready) begin
                r_out_valid <= do_step && emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_step) begin
            r_kind     <= e_kind;
            r_value    <= e_value;
            r_out_addr <= e_addr;
            r_out_func <= e_func;
            r_last     <= !first_half;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_kind           = r_kind;
    assign o_value          = r_value;
    assign o_frame_address  = r_out_addr;
    assign o_frame_function = r_out_func;
    assign o_last           = r_last;

`ifndef SYNTH
    a_second_half: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_second |-> i_head_valid && i_head.cmd == dsfr_pkg::CMD_PUSH2)
        else $error("second half pending without an escaped pair at the head");
    a_split_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_step && first_half |=> r_second && i_head_valid)
        else $error("escaped pair not split into two steps");
    a_abort_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_kind == dsfr_pkg::K_ABORT |-> r_value == 8'h00 && r_last)
        else $error("abort result carries data or is not last");
`endif

endmodule

@@ hdl/dle_stx_etx_frame_receiver.sv @@
// DLE STX/ETX frame receiver.
// Input channel: one raw serial byte per transfer on i_rx_byte (i_rx_valid,
// o_rx_stall). Output channel: result items on o_kind, o_value,
// o_frame_address, o_frame_function and o_last (o_valid, i_stall).
// A frame opens with DLE STX and closes with DLE ETX; DLE DLE is a literal
// 0x10 and any other DLE pair passes both bytes. Payload bytes come out one
// byte late, so the trailing checksum is never passed as payload. At DLE ETX
// of a non-empty frame one verdict item (good, checksum error, too short)
// carries the checksum. DLE STX inside a frame yields an abort item and
// restarts the frame. A transferred byte enters the command queue, the back
// end steps it and the output register raises o_valid. Throughput: one byte
// per cycle while o_rx_stall is low; a DLE-plus-data pair that yields two
// payload items is split into DLE and data steps by the back end, absorbed
// by the four-entry queue. o_last marks the final item of one input byte.
// Config: i_cfg_we writes i_cfg_data to register i_cfg_index (0: checksum
// extra offset, 1: strip null preamble); write only while idle.
// Reset (synchronous, active low): phase idle, empty frame, offset 5,
// preamble stripping on. When i_stall holds the output, the back end stops,
// the queue fills and o_rx_stall rises; nothing is lost.
module dle_stx_etx_frame_receiver #(
    parameter int QUEUE_DEPTH = dsfr_pkg::QUEUE_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_rx_valid,
    output logic                              o_rx_stall,
    input  logic [7:0]                        i_rx_byte,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [2:0]                        o_kind,
    output logic [7:0]                        o_value,
    output logic [7:0]                        o_frame_address,
    output logic [7:0]                        o_frame_function,
    output logic                              o_last,
    input  logic                              i_cfg_we,
    input  logic [dsfr_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [dsfr_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    dsfr_pkg::t_cfg    r_cfg;
    logic              q_push;
    logic              q_pop;
    logic              q_valid;
    logic              q_full;
    dsfr_pkg::t_qentry q_in;
    dsfr_pkg::t_qentry q_head;

    // Configuration registers; writes to unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.checksum_extra_offset <= dsfr_pkg::OFFSET_RESET;
            r_cfg.strip_null_preamble   <= dsfr_pkg::STRIP_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                dsfr_pkg::CFG_CHECKSUM_EXTRA_OFFSET: begin
                    r_cfg.checksum_extra_offset <= i_cfg_data[7:0];
                end
                dsfr_pkg::CFG_STRIP_NULL_PREAMBLE: begin
                    r_cfg.strip_null_preamble <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    // Stall the byte stream only when the command queue is full.
    assign o_rx_stall = q_full;

    // Front: track framing phase, turn bytes into commands.
    dsfr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_rx_valid),
        .i_byte  (i_rx_byte),
        .i_full  (q_full),
        .o_push  (q_push),
        .o_entry (q_in)
    );

    dsfr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_head  (q_head),
        .o_full  (q_full)
    );

    // Back: frame bookkeeping, checksum verdict and the output register.
    dsfr_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_head_valid     (q_valid),
        .i_head           (q_head),
        .o_pop            (q_pop),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_kind           (o_kind),
        .o_value          (o_value),
        .o_frame_address  (o_frame_address),
        .o_frame_function (o_frame_function),
        .o_last           (o_last)
    );

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps

module tb;

    localparam int CLK_HALF    = 6;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 8;

    // Receive phases of the deframer, mirrored by the checker below.
    typedef enum logic [1:0] {
        RX_IDLE   = 2'd0,
        RX_SYNC   = 2'd1,
        RX_DATA   = 2'd2,
        RX_ESCAPE = 2'd3
    } t_rx_phase;

    // How the trailing checksum byte of a generated frame is formed.
    typedef enum int {
        CS_GOOD,
        CS_ALT,
        CS_FLIPPED,
        CS_RANDOM,
        CS_ZERO
    } t_csum_mode;

    typedef struct {
        dsfr_pkg::t_kind kind;
        logic [7:0]      value;
        logic [7:0]      address;
        logic [7:0]      func;
        logic            last;
    } t_frame_result;

    typedef logic [7:0] t_byte_q[$];

    // Tracks the deframer state per received byte and holds the results owed.
    class deframe_checker;
        logic [7:0]    extra_offset;
        logic          strip_nulls;
        t_rx_phase     phase;
        logic [7:0]    held_byte;
        logic          held_valid;
        logic [7:0]    running_sum;
        logic [1:0]    total_count;
        logic [1:0]    kept_count;
        logic [7:0]    address_seen;
        logic [7:0]    function_seen;
        t_frame_result step_results[$];
        t_frame_result owed_results[$];
        int            errors;

        function new();
            errors = 0;
            extra_offset = dsfr_pkg::OFFSET_RESET;
            strip_nulls  = dsfr_pkg::STRIP_RESET;
            phase        = RX_IDLE;
            clear_frame();
        endfunction

        function void clear_frame();
            held_byte     = 8'h00;
            held_valid    = 1'b0;
            running_sum   = dsfr_pkg::SUM_SEED;
            total_count   = 2'd0;
            kept_count    = 2'd0;
            address_seen  = 8'h00;
            function_seen = 8'h00;
        endfunction

        function void set_register(logic [dsfr_pkg::CFG_INDEX_W-1:0] idx,
                                   logic [dsfr_pkg::CFG_DATA_W-1:0] data);
            if (idx == dsfr_pkg::CFG_CHECKSUM_EXTRA_OFFSET)
                extra_offset = data[7:0];
            else if (idx == dsfr_pkg::CFG_STRIP_NULL_PREAMBLE)
                strip_nulls = data[0];
        endfunction

        function void add_result(dsfr_pkg::t_kind kind, logic [7:0] value);
            t_frame_result r;
            if (step_results.size() >= 2)
                return;
            r.kind    = kind;
            r.value   = value;
            r.address = address_seen;
            r.func    = function_seen;
            r.last    = 1'b0;
            step_results = {step_results, r};
        endfunction

        // One decoded data byte: drop preamble nulls, latch address and
        // function, release the previously held byte as payload.
        function void take_data(logic [7:0] b);
            if (total_count != 2'd3)
                total_count++;
            if (strip_nulls && kept_count == 2'd0 && b == dsfr_pkg::NULL_BYTE)
                return;
            if (kept_count == 2'd0)
                address_seen = b;
            else if (kept_count == 2'd1)
                function_seen = b;
            if (kept_count != 2'd3)
                kept_count++;
            if (held_valid) begin
                running_sum = running_sum + held_byte;
                add_result(dsfr_pkg::K_PAYLOAD, held_byte);
            end
            held_byte  = b;
            held_valid = 1'b1;
        endfunction

        // Judge the frame at DLE ETX: length first, then checksum, then kept bytes.
        function void judge_frame();
            logic [7:0]      received;
            logic [7:0]      alt_sum;
            dsfr_pkg::t_kind verdict;
            received = held_valid ? held_byte : 8'h00;
            alt_sum  = running_sum + extra_offset;
            if (total_count == 2'd0)
                return;
            if (total_count < 2'd3)
                verdict = dsfr_pkg::K_TOO_SHORT;
            else if (running_sum != received && alt_sum != received)
                verdict = dsfr_pkg::K_CSUM_ERR;
            else if (kept_count < 2'd3)
                verdict = dsfr_pkg::K_TOO_SHORT;
            else
                verdict = dsfr_pkg::K_GOOD;
            add_result(verdict, received);
        endfunction

        function void note_rx_byte(logic [7:0] b);
            step_results.delete();
            case (phase)
                RX_IDLE: begin
                    if (b == dsfr_pkg::DLE_BYTE)
                        phase = RX_SYNC;
                end
                RX_SYNC: begin
                    if (b == dsfr_pkg::STX_BYTE) begin
                        clear_frame();
                        phase = RX_DATA;
                    end else begin
                        phase = RX_IDLE;
                    end
                end
                RX_DATA: begin
                    if (b == dsfr_pkg::DLE_BYTE)
                        phase = RX_ESCAPE;
                    else
                        take_data(b);
                end
                default: begin
                    if (b == dsfr_pkg::ETX_BYTE) begin
                        judge_frame();
                        clear_frame();
                        phase = RX_IDLE;
                    end else if (b == dsfr_pkg::DLE_BYTE) begin
                        take_data(dsfr_pkg::DLE_BYTE);
                        phase = RX_DATA;
                    end else if (b == dsfr_pkg::STX_BYTE) begin
                        add_result(dsfr_pkg::K_ABORT, 8'h00);
                        clear_frame();
                        phase = RX_DATA;
                    end else begin
                        take_data(dsfr_pkg::DLE_BYTE);
                        take_data(b);
                        phase = RX_DATA;
                    end
                end
            endcase
            if (step_results.size() > 0)
                step_results[step_results.size() - 1].last = 1'b1;
            owed_results = {owed_results, step_results};
        endfunction

        function void check_result(logic [2:0] kind, logic [7:0] value, logic [7:0] address,
                                   logic [7:0] func, logic last);
            t_frame_result want;
            if (owed_results.size() == 0) begin
                $error("unexpected result: kind %0d value %02h", kind, value);
                errors++;
                return;
            end
            want = owed_results[0];
            owed_results.delete(0);
            if (kind !== want.kind) begin
                $error("kind: expected %0d, got %0d", want.kind, kind);
                errors++;
            end
            if (value !== want.value) begin
                $error("value: expected %02h, got %02h", want.value, value);
                errors++;
            end
            if (address !== want.address) begin
                $error("frame_address: expected %02h, got %02h", want.address, address);
                errors++;
            end
            if (func !== want.func) begin
                $error("frame_function: expected %02h, got %02h", want.func, func);
                errors++;
            end
            if (last !== want.last) begin
                $error("last: expected %0d, got %0d", want.last, last);
                errors++;
            end
        endfunction

        function int pending();
            return owed_results.size();
        endfunction
    endclass

    logic                             i_clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             rx_valid = 1'b0;
    logic [7:0]                       rx_byte = 8'h00;
    logic                             stall = 1'b0;
    logic                             cfg_we = 1'b0;
    logic [dsfr_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [dsfr_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

    logic       o_rx_stall;
    logic       o_valid;
    logic [2:0] o_kind;
    logic [7:0] o_value;
    logic [7:0] o_frame_address;
    logic [7:0] o_frame_function;
    logic       o_last;

    // When set, both sides run without gaps or stalls.
    logic steady = 1'b0;
    int   framed_bytes = 0;

    deframe_checker sb = new();

    dle_stx_etx_frame_receiver dut (
        .i_clk            (i_clk),
        .i_rst_n          (rst_n),
        .i_rx_valid       (rx_valid),
        .o_rx_stall       (o_rx_stall),
        .i_rx_byte        (rx_byte),
        .o_valid          (o_valid),
        .i_stall          (stall),
        .o_kind           (o_kind),
        .o_value          (o_value),
        .o_frame_address  (o_frame_address),
        .o_frame_function (o_frame_function),
        .o_last           (o_last),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Sample both channels at the rising edge. Check the output transfer
    // first: results of a byte taken at this edge show up no earlier than
    // the next edge.
    always @(posedge i_clk) begin
        if (rst_n) begin
            if (o_valid && !stall)
                sb.check_result(o_kind, o_value, o_frame_address, o_frame_function, o_last);
            if (rx_valid && !o_rx_stall)
                sb.note_rx_byte(rx_byte);
        end
    end

    // Result side: hold stall for a random number of cycles per result,
    // then take one result.
    initial begin
        int hold;
        @(posedge rst_n);
        forever begin
            hold = steady ? 0 : $urandom_range(0, 4);
            if (hold > 0) begin
                stall <= 1'b1;
                repeat (hold) @(negedge i_clk);
            end
            stall <= 1'b0;
            @(posedge i_clk);
            while (!o_valid)
                @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("** dle_stx_etx_frame_receiver: FAILED **");
        $finish;
    end

    // Present one byte after a random gap; return at the falling edge after
    // the transfer with valid still high.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            rx_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        rx_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge i_clk);
        while (o_rx_stall)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Stop the byte stream and let every owed result drain.
    task automatic wait_drained();
        rx_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_cfg(input logic [dsfr_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [dsfr_pkg::CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        sb.set_register(idx, data);
        @(negedge i_clk);
    endtask

    function automatic logic [7:0] pick_data_byte();
        case ($urandom_range(0, 7))
            0, 1:    return dsfr_pkg::DLE_BYTE;
            2:       return dsfr_pkg::STX_BYTE;
            3:       return dsfr_pkg::ETX_BYTE;
            4:       return dsfr_pkg::NULL_BYTE;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic t_byte_q make_body();
        t_byte_q body;
        int      len;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 14) : $urandom_range(0, 5);
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2)) body = {body, dsfr_pkg::NULL_BYTE};
        repeat (len) body = {body, pick_data_byte()};
        return body;
    endfunction

    function automatic t_csum_mode pick_mode();
        case ($urandom_range(0, 7))
            0, 1, 2, 3: return CS_GOOD;
            4, 5:       return CS_ALT;
            6:          return CS_FLIPPED;
            default:    return CS_RANDOM;
        endcase
    endfunction

    // Frame the body with DLE STX ... checksum DLE ETX. Stuff DLE bytes,
    // but now and then leave a lone DLE where the next byte is ordinary:
    // the unknown pair decodes to the same two bytes.
    task automatic send_frame(input t_byte_q body, input t_csum_mode mode);
        t_byte_q    data;
        logic [7:0] plain_sum;
        logic [7:0] csum;
        logic [7:0] nxt;
        int         count;
        plain_sum = dsfr_pkg::SUM_SEED;
        foreach (body[i])
            plain_sum = plain_sum + body[i];
        case (mode)
            CS_GOOD:    csum = plain_sum;
            CS_ALT:     csum = plain_sum + sb.extra_offset;
            CS_FLIPPED: csum = plain_sum ^ 8'h80;
            CS_ZERO:    csum = 8'h00;
            default:    csum = 8'($urandom_range(0, 255));
        endcase
        data = {body, csum};
        send_byte(dsfr_pkg::DLE_BYTE);
        send_byte(dsfr_pkg::STX_BYTE);
        count = 4;
        for (int i = 0; i < data.size(); i++) begin
            send_byte(data[i]);
            count++;
            if (data[i] == dsfr_pkg::DLE_BYTE) begin
                nxt = (i + 1 < data.size()) ? data[i + 1] : dsfr_pkg::DLE_BYTE;
                if (nxt == dsfr_pkg::DLE_BYTE || nxt == dsfr_pkg::STX_BYTE
                        || nxt == dsfr_pkg::ETX_BYTE || $urandom_range(0, 1) == 0) begin
                    send_byte(dsfr_pkg::DLE_BYTE);
                    count++;
                end
            end
        end
        send_byte(dsfr_pkg::DLE_BYTE);
        send_byte(dsfr_pkg::ETX_BYTE);
        framed_bytes += count;
    endtask

    task automatic send_empty_frame();
        send_byte(dsfr_pkg::DLE_BYTE);
        send_byte(dsfr_pkg::STX_BYTE);
        send_byte(dsfr_pkg::DLE_BYTE);
        send_byte(dsfr_pkg::ETX_BYTE);
        framed_bytes += 4;
    endtask

    // Mostly well-formed frames with random content; the rest is line
    // noise, frames cut short by a new DLE STX, and empty frames.
    task automatic random_traffic(input int target);
        int         start;
        int         choice;
        logic [7:0] b;
        start = framed_bytes;
        while (framed_bytes - start < target) begin
            steady = ($urandom_range(0, 5) == 0);
            choice = $urandom_range(0, 9);
            if (choice < 7) begin
                send_frame(make_body(), pick_mode());
            end else if (choice == 7) begin
                repeat ($urandom_range(1, 3)) begin
                    b = ($urandom_range(0, 3) == 0) ? dsfr_pkg::DLE_BYTE
                                                    : 8'($urandom_range(0, 255));
                    send_byte(b);
                end
            end else if (choice == 8) begin
                send_byte(dsfr_pkg::DLE_BYTE);
                send_byte(dsfr_pkg::STX_BYTE);
                framed_bytes += 2;
                repeat ($urandom_range(0, 4)) begin
                    b = pick_data_byte();
                    send_byte(b);
                    framed_bytes++;
                    if (b == dsfr_pkg::DLE_BYTE) begin
                        send_byte(dsfr_pkg::DLE_BYTE);
                        framed_bytes++;
                    end
                end
                send_frame(make_body(), pick_mode());
            end else begin
                send_empty_frame();
            end
        end
        steady = 1'b0;
    endtask

    initial begin
        t_byte_q body;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part, reset settings (offset 5, strip on).
        // Bytes outside a frame, and DLE followed by DLE while idle.
        send_byte(8'hFF);
        send_byte(dsfr_pkg::DLE_BYTE);
        send_byte(dsfr_pkg::DLE_BYTE);
        send_empty_frame();
        // Preamble null, stuffed or lone DLE, good checksum.
        body = {dsfr_pkg::NULL_BYTE, 8'h01, dsfr_pkg::DLE_BYTE, 8'h7F};
        send_frame(body, CS_GOOD);
        // Alternate checksum with offset added, extreme data values.
        body = {8'hFF, 8'h80, 8'h00};
        send_frame(body, CS_ALT);
        body = {8'h42, 8'h81, 8'h01};
        send_frame(body, CS_FLIPPED);
        // Too few data bytes.
        body = {8'h21};
        send_frame(body, CS_GOOD);
        // All nulls: every byte stripped, checksum reads as zero.
        body = {dsfr_pkg::NULL_BYTE, dsfr_pkg::NULL_BYTE, dsfr_pkg::NULL_BYTE};
        send_frame(body, CS_ZERO);
        // Checksum passes but only two kept bytes after the preamble.
        body = {dsfr_pkg::NULL_BYTE, dsfr_pkg::NULL_BYTE, 8'h07};
        send_frame(body, CS_GOOD);
        // DLE STX inside a frame aborts it and opens a new one.
        send_byte(dsfr_pkg::DLE_BYTE);
        send_byte(dsfr_pkg::STX_BYTE);
        send_byte(8'h33);
        body = {8'h44, 8'h55, 8'h66};
        send_frame(body, CS_GOOD);

        random_traffic(70);

        // Walk through register settings, extremes included.
        for (int p = 1; p <= 4; p++) begin
            wait_drained();
            case (p)
                1: begin
                    write_cfg(dsfr_pkg::CFG_CHECKSUM_EXTRA_OFFSET, 8'h00);
                    write_cfg(dsfr_pkg::CFG_STRIP_NULL_PREAMBLE, 8'h00);
                end
                2: begin
                    write_cfg(dsfr_pkg::CFG_CHECKSUM_EXTRA_OFFSET, 8'hFF);
                    write_cfg(dsfr_pkg::CFG_STRIP_NULL_PREAMBLE, 8'h01);
                end
                3: begin
                    write_cfg(dsfr_pkg::CFG_CHECKSUM_EXTRA_OFFSET, 8'($urandom_range(0, 255)));
                    write_cfg(dsfr_pkg::CFG_STRIP_NULL_PREAMBLE, 8'h00);
                end
                default: begin
                    write_cfg(dsfr_pkg::CFG_CHECKSUM_EXTRA_OFFSET, 8'($urandom_range(0, 255)));
                    write_cfg(dsfr_pkg::CFG_STRIP_NULL_PREAMBLE, 8'($urandom_range(0, 1)));
                end
            endcase
            random_traffic(70);
        end

        wait_drained();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("** dle_stx_etx_frame_receiver: PASSED **");
        else
            $display("** dle_stx_etx_frame_receiver: FAILED **");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/dsfr_pkg.sv
hdl/dsfr_front.sv
hdl/dsfr_queue.sv
hdl/dsfr_back.sv
hdl/dle_stx_etx_frame_receiver.sv
sim/tb.sv
